/* hdl/ir_pulse_distance_transmitter_assert.svh */
// Assertion macros for the pulse-distance infrared transmitter.
`ifndef IR_PULSE_DISTANCE_TRANSMITTER_ASSERT_SVH
`define IR_PULSE_DISTANCE_TRANSMITTER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define IRPDT_ASSERT_NOW(label, clk, rst_n, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error("irpdt: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define IRPDT_ASSERT_NEXT(label, clk, rst_n, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error("irpdt: next-cycle check failed");

`endif

/* hdl/irpdt_pkg.sv */
// Shared types and constants for the pulse-distance infrared transmitter.
package irpdt_pkg;

    localparam int IRPDT_FRAME_BITS_DEF     = 32;
    localparam int IRPDT_DURATION_WIDTH_DEF = 20;
    localparam int IRPDT_CARRIER_WIDTH_DEF  = 8;

    localparam int IRPDT_WORD_WIDTH      = 32;
    localparam int IRPDT_CFG_INDEX_WIDTH = 3;

    localparam logic [IRPDT_CFG_INDEX_WIDTH-1:0] IRPDT_REG_CARRIER_TOP     = 3'd0;
    localparam logic [IRPDT_CFG_INDEX_WIDTH-1:0] IRPDT_REG_CARRIER_COMPARE = 3'd1;
    localparam logic [IRPDT_CFG_INDEX_WIDTH-1:0] IRPDT_REG_HEADER_MARK     = 3'd2;
    localparam logic [IRPDT_CFG_INDEX_WIDTH-1:0] IRPDT_REG_HEADER_SPACE    = 3'd3;
    localparam logic [IRPDT_CFG_INDEX_WIDTH-1:0] IRPDT_REG_BIT_MARK        = 3'd4;
    localparam logic [IRPDT_CFG_INDEX_WIDTH-1:0] IRPDT_REG_ONE_SPACE       = 3'd5;
    localparam logic [IRPDT_CFG_INDEX_WIDTH-1:0] IRPDT_REG_ZERO_SPACE      = 3'd6;

    localparam int IRPDT_CARRIER_TOP_RST     = 210;
    localparam int IRPDT_CARRIER_COMPARE_RST = 70;
    localparam int IRPDT_HEADER_MARK_RST     = 40000;
    localparam int IRPDT_HEADER_SPACE_RST    = 40000;
    localparam int IRPDT_BIT_MARK_RST        = 4480;
    localparam int IRPDT_ONE_SPACE_RST       = 12800;
    localparam int IRPDT_ZERO_SPACE_RST      = 4480;

    typedef struct packed {
        logic ir_drive;
        logic envelope;
        logic busy_res;
        logic start_rejected;
    } irpdt_result_t;

endpackage

/* hdl/irpdt_if.sv */
// Item and result channel interfaces.
interface irpdt_in_if;
    import irpdt_pkg::*;

    logic                        valid;
    logic                        ready;
    logic                        cmd;
    logic [IRPDT_WORD_WIDTH-1:0] frame_word;

    modport source (output valid, output cmd, output frame_word, input ready);
    modport sink   (input valid, input cmd, input frame_word, output ready);
endinterface

interface irpdt_out_if;
    logic valid;
    logic ready;
    logic ir_drive;
    logic envelope;
    logic busy_res;
    logic start_rejected;

    modport source (output valid, output ir_drive, output envelope, output busy_res,
                    output start_rejected, input ready);
    modport sink   (input valid, input ir_drive, input envelope, input busy_res,
                    input start_rejected, output ready);
endinterface

/* hdl/ir_pulse_distance_transmitter.sv */
// Pulse-distance infrared transmitter, top level.
// Latency: a result beat is valid the cycle after its item is accepted, unless an earlier beat still waits.
// Throughput: one item per cycle while the result buffer has room; the frame state updates in a single pass per item.
// A two-entry result buffer keeps item.ready high while one result waits downstream.
// Reset: asynchronous, active low; frame idle, counters zero, registers at defaults.
module ir_pulse_distance_transmitter #(
    parameter int FRAME_BITS     = irpdt_pkg::IRPDT_FRAME_BITS_DEF,
    parameter int DURATION_WIDTH = irpdt_pkg::IRPDT_DURATION_WIDTH_DEF,
    parameter int CARRIER_WIDTH  = irpdt_pkg::IRPDT_CARRIER_WIDTH_DEF,
    parameter int CFG_WIDTH      = (DURATION_WIDTH > CARRIER_WIDTH) ? DURATION_WIDTH
                                                                    : CARRIER_WIDTH
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        cfg_we,
    input  logic [irpdt_pkg::IRPDT_CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_WIDTH-1:0]                        cfg_data,
    irpdt_in_if.sink                                    item,
    irpdt_out_if.source                                 result
);
    import irpdt_pkg::*;

    `include "ir_pulse_distance_transmitter_assert.svh"

    irpdt_result_t result_next;
    logic          push_ready;
    logic          item_fire;

    assign item.ready = push_ready;
    assign item_fire  = item.valid && push_ready;

    irpdt_core #(
        .FRAME_BITS     (FRAME_BITS),
        .DURATION_WIDTH (DURATION_WIDTH),
        .CARRIER_WIDTH  (CARRIER_WIDTH),
        .CFG_WIDTH      (CFG_WIDTH)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .item_fire   (item_fire),
        .cmd         (item.cmd),
        .frame_word  (item.frame_word),
        .result_next (result_next)
    );

    irpdt_outbuf u_outbuf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (item_fire),
        .push_ready (push_ready),
        .push_data  (result_next),
        .result     (result)
    );

    // a rejected start only happens mid-frame
    `IRPDT_ASSERT_NOW(a_reject_busy, clk, rst_n, result.valid && result.start_rejected,
                      result.busy_res)
    `IRPDT_ASSERT_NOW(a_drive_in_mark, clk, rst_n, result.valid && result.ir_drive,
                      result.envelope)
    `IRPDT_ASSERT_NEXT(a_beat_follows, clk, rst_n, item.valid && item.ready, result.valid)

endmodule

/* hdl/irpdt_core.sv */
// Frame sequencer, carrier counter and configuration registers.
module irpdt_core #(
    parameter int FRAME_BITS     = irpdt_pkg::IRPDT_FRAME_BITS_DEF,
    parameter int DURATION_WIDTH = irpdt_pkg::IRPDT_DURATION_WIDTH_DEF,
    parameter int CARRIER_WIDTH  = irpdt_pkg::IRPDT_CARRIER_WIDTH_DEF,
    parameter int CFG_WIDTH      = (DURATION_WIDTH > CARRIER_WIDTH) ? DURATION_WIDTH
                                                                    : CARRIER_WIDTH
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        cfg_we,
    input  logic [irpdt_pkg::IRPDT_CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_WIDTH-1:0]                        cfg_data,
    input  logic                                        item_fire,
    input  logic                                        cmd,
    input  logic [irpdt_pkg::IRPDT_WORD_WIDTH-1:0]      frame_word,
    output irpdt_pkg::irpdt_result_t                    result_next
);
    import irpdt_pkg::*;

    localparam int BITS_W = $clog2(FRAME_BITS + 1);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HDR_MARK,
        PH_HDR_SPACE,
        PH_BIT_MARK,
        PH_BIT_SPACE,
        PH_TRAILER
    } phase_t;

    phase_t                    phase_reg, phase_next;
    logic [DURATION_WIDTH-1:0] seg_reg, seg_next;
    logic [FRAME_BITS-1:0]     shift_reg, shift_next;
    logic [BITS_W-1:0]         bits_left_reg, bits_left_next;
    logic [CARRIER_WIDTH-1:0]  carrier_reg, carrier_next;

    logic [CARRIER_WIDTH-1:0]  top_reg, compare_reg;
    logic [DURATION_WIDTH-1:0] hdr_mark_reg, hdr_space_reg, bit_mark_reg;
    logic [DURATION_WIDTH-1:0] one_space_reg, zero_space_reg;

    logic [DURATION_WIDTH-1:0] seg_len;
    logic [DURATION_WIDTH-1:0] seg_plus;
    logic                      seg_done;
    logic [BITS_W-1:0]         bits_dec;
    logic                      env;

    always_comb
    begin
        case (phase_reg)
            PH_HDR_MARK:  seg_len = hdr_mark_reg;
            PH_HDR_SPACE: seg_len = hdr_space_reg;
            PH_BIT_MARK:  seg_len = bit_mark_reg;
            PH_TRAILER:   seg_len = bit_mark_reg;
            PH_BIT_SPACE: seg_len = shift_reg[FRAME_BITS-1] ? one_space_reg : zero_space_reg;
            default:      seg_len = DURATION_WIDTH'(1);
        endcase
    end

    assign seg_plus = seg_reg + 1'b1;
    // a zero length, or a count that wraps, ends the segment at once
    assign seg_done = (seg_len == '0) || (seg_plus == '0) || (seg_plus >= seg_len);
    assign bits_dec = (bits_left_reg != '0) ? bits_left_reg - 1'b1 : '0;

    always_comb
    begin
        phase_next                 = phase_reg;
        seg_next                   = seg_reg;
        shift_next                 = shift_reg;
        bits_left_next             = bits_left_reg;
        carrier_next               = carrier_reg;
        result_next.start_rejected = 1'b0;
        if (item_fire)
        begin
            if (cmd)
            begin
                if (phase_reg != PH_IDLE)
                begin
                    result_next.start_rejected = 1'b1;
                end
                else
                begin
                    shift_next     = frame_word[FRAME_BITS-1:0];
                    bits_left_next = BITS_W'(FRAME_BITS);
                    seg_next       = '0;
                    phase_next     = PH_HDR_MARK;
                end
            end
            else
            begin
                carrier_next = (carrier_reg >= top_reg) ? '0 : carrier_reg + 1'b1;
                if (phase_reg != PH_IDLE)
                begin
                    if (seg_done)
                    begin
                        seg_next = '0;
                        case (phase_reg)
                            PH_HDR_MARK:  phase_next = PH_HDR_SPACE;
                            PH_HDR_SPACE: phase_next = PH_BIT_MARK;
                            PH_BIT_MARK:  phase_next = PH_BIT_SPACE;
                            PH_BIT_SPACE:
                            begin
                                shift_next     = shift_reg << 1;
                                bits_left_next = bits_dec;
                                phase_next     = (bits_dec != '0) ? PH_BIT_MARK : PH_TRAILER;
                            end
                            default:      phase_next = PH_IDLE;
                        endcase
                    end
                    else
                    begin
                        seg_next = seg_plus;
                    end
                end
            end
        end
        env = (phase_next == PH_HDR_MARK) || (phase_next == PH_BIT_MARK) ||
              (phase_next == PH_TRAILER);
        result_next.envelope = env;
        result_next.ir_drive = env && (carrier_next < compare_reg);
        result_next.busy_res = (phase_next != PH_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            seg_reg        <= '0;
            shift_reg      <= '0;
            bits_left_reg  <= '0;
            carrier_reg    <= '0;
            top_reg        <= CARRIER_WIDTH'(IRPDT_CARRIER_TOP_RST);
            compare_reg    <= CARRIER_WIDTH'(IRPDT_CARRIER_COMPARE_RST);
            hdr_mark_reg   <= DURATION_WIDTH'(IRPDT_HEADER_MARK_RST);
            hdr_space_reg  <= DURATION_WIDTH'(IRPDT_HEADER_SPACE_RST);
            bit_mark_reg   <= DURATION_WIDTH'(IRPDT_BIT_MARK_RST);
            one_space_reg  <= DURATION_WIDTH'(IRPDT_ONE_SPACE_RST);
            zero_space_reg <= DURATION_WIDTH'(IRPDT_ZERO_SPACE_RST);
        end
        else
        begin
            phase_reg     <= phase_next;
            seg_reg       <= seg_next;
            shift_reg     <= shift_next;
            bits_left_reg <= bits_left_next;
            carrier_reg   <= carrier_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    IRPDT_REG_CARRIER_TOP:     top_reg        <= cfg_data[CARRIER_WIDTH-1:0];
                    IRPDT_REG_CARRIER_COMPARE: compare_reg    <= cfg_data[CARRIER_WIDTH-1:0];
                    IRPDT_REG_HEADER_MARK:     hdr_mark_reg   <= cfg_data[DURATION_WIDTH-1:0];
                    IRPDT_REG_HEADER_SPACE:    hdr_space_reg  <= cfg_data[DURATION_WIDTH-1:0];
                    IRPDT_REG_BIT_MARK:        bit_mark_reg   <= cfg_data[DURATION_WIDTH-1:0];
                    IRPDT_REG_ONE_SPACE:       one_space_reg  <= cfg_data[DURATION_WIDTH-1:0];
                    IRPDT_REG_ZERO_SPACE:      zero_space_reg <= cfg_data[DURATION_WIDTH-1:0];
                    default:                   ;
                endcase
            end
        end
    end

endmodule

/* hdl/irpdt_outbuf.sv */
// Two-entry result buffer; ready is registered and drops only when both entries hold beats.
module irpdt_outbuf (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push_valid,
    output logic                     push_ready,
    input  irpdt_pkg::irpdt_result_t push_data,
    irpdt_out_if.source              result
);
    import irpdt_pkg::*;

    irpdt_result_t main_reg, main_next;
    irpdt_result_t spare_reg, spare_next;
    logic          main_valid_reg, main_valid_next;
    logic          spare_valid_reg, spare_valid_next;
    logic          push;
    logic          pop;

    assign push_ready = !spare_valid_reg;
    assign push       = push_valid && push_ready;
    assign pop        = main_valid_reg && result.ready;

    always_comb
    begin
        main_next        = main_reg;
        spare_next       = spare_reg;
        main_valid_next  = main_valid_reg;
        spare_valid_next = spare_valid_reg;
        if (!main_valid_reg || pop)
        begin
            if (spare_valid_reg)
            begin
                main_next        = spare_reg;
                main_valid_next  = 1'b1;
                spare_next       = push_data;
                spare_valid_next = push;
            end
            else
            begin
                main_next       = push_data;
                main_valid_next = push;
            end
        end
        else if (push)
        begin
            spare_next       = push_data;
            spare_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg  <= 1'b0;
            spare_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg  <= main_valid_next;
            spare_valid_reg <= spare_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg  <= main_next;
        spare_reg <= spare_next;
    end

    assign result.valid          = main_valid_reg;
    assign result.ir_drive       = main_reg.ir_drive;
    assign result.envelope       = main_reg.envelope;
    assign result.busy_res       = main_reg.busy_res;
    assign result.start_rejected = main_reg.start_rejected;

endmodule

/* verif/irpdt_checker.sv */
// Scoreboard for the infrared transmitter: predicts each result beat and compares it.
`timescale 1ns / 100ps
module irpdt_checker #(
    parameter int CFG_W = (irpdt_pkg::IRPDT_DURATION_WIDTH_DEF >
                           irpdt_pkg::IRPDT_CARRIER_WIDTH_DEF)
                          ? irpdt_pkg::IRPDT_DURATION_WIDTH_DEF
                          : irpdt_pkg::IRPDT_CARRIER_WIDTH_DEF
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        cfg_we,
    input  logic [irpdt_pkg::IRPDT_CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_W-1:0]                            cfg_data,
    irpdt_in_if                                         item,
    irpdt_out_if                                        result,
    output int                                          mismatches,
    output int                                          pending,
    output int                                          beats_checked,
    output int                                          frames_done,
    output int                                          starts_refused,
    output logic                                        frame_busy
);
    import irpdt_pkg::*;

    localparam int DUR_W       = IRPDT_DURATION_WIDTH_DEF;
    localparam int CAR_W       = IRPDT_CARRIER_WIDTH_DEF;
    localparam int WORD_BITS   = IRPDT_FRAME_BITS_DEF;
    localparam int MAX_REPORTS = 10;

    typedef enum logic [2:0] {
        TX_IDLE,
        TX_HDR_MARK,
        TX_HDR_SPACE,
        TX_BIT_MARK,
        TX_BIT_SPACE,
        TX_TRAILER
    } tx_phase_t;

    logic [CAR_W-1:0] carrier_top;
    logic [CAR_W-1:0] carrier_compare;
    logic [DUR_W-1:0] header_mark;
    logic [DUR_W-1:0] header_space;
    logic [DUR_W-1:0] bit_mark;
    logic [DUR_W-1:0] one_space;
    logic [DUR_W-1:0] zero_space;

    tx_phase_t                       phase;
    logic [DUR_W-1:0]                seg_cnt;
    logic [IRPDT_WORD_WIDTH-1:0]     shift_word;
    logic [5:0]                      bits_left;
    logic [CAR_W-1:0]                carrier_cnt;

    irpdt_result_t expected_q[$];

    function automatic logic [DUR_W-1:0] segment_length();
        case (phase)
            TX_HDR_MARK:  return header_mark;
            TX_HDR_SPACE: return header_space;
            TX_BIT_MARK:  return bit_mark;
            TX_TRAILER:   return bit_mark;
            TX_BIT_SPACE: return shift_word[IRPDT_WORD_WIDTH-1] ? one_space : zero_space;
            default:      return DUR_W'(1);
        endcase
    endfunction

    function automatic void next_segment();
        case (phase)
            TX_HDR_MARK:  phase = TX_HDR_SPACE;
            TX_HDR_SPACE: phase = TX_BIT_MARK;
            TX_BIT_MARK:  phase = TX_BIT_SPACE;
            TX_BIT_SPACE:
            begin
                shift_word = shift_word << 1;
                if (bits_left != 0)
                    bits_left = bits_left - 1'b1;
                phase = (bits_left != 0) ? TX_BIT_MARK : TX_TRAILER;
            end
            TX_TRAILER:
            begin
                phase = TX_IDLE;
                frames_done++;
            end
            default:      phase = TX_IDLE;
        endcase
        seg_cnt = '0;
    endfunction

    // one accepted beat: start or tick, result is the state after it
    function automatic irpdt_result_t transmit_step(input logic start,
                                                    input logic [IRPDT_WORD_WIDTH-1:0] word);
        irpdt_result_t    r;
        logic [DUR_W-1:0] len;
        logic [DUR_W-1:0] nxt;
        logic             env;
        r = '0;
        if (start)
        begin
            if (phase != TX_IDLE)
            begin
                r.start_rejected = 1'b1;
                starts_refused++;
            end
            else
            begin
                shift_word = word;
                bits_left  = 6'(WORD_BITS);
                seg_cnt    = '0;
                phase      = TX_HDR_MARK;
            end
        end
        else
        begin
            carrier_cnt = (carrier_cnt >= carrier_top) ? '0 : carrier_cnt + 1'b1;
            if (phase != TX_IDLE)
            begin
                len = segment_length();
                nxt = seg_cnt + 1'b1;
                if (len == 0 || nxt == 0 || nxt >= len)
                    next_segment();
                else
                    seg_cnt = nxt;
            end
        end
        env = (phase == TX_HDR_MARK) || (phase == TX_BIT_MARK) || (phase == TX_TRAILER);
        r.envelope = env;
        r.ir_drive = env && (carrier_cnt < carrier_compare);
        r.busy_res = (phase != TX_IDLE);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        irpdt_result_t got;
        irpdt_result_t exp;
        if (!rst_n)
        begin
            carrier_top     = CAR_W'(IRPDT_CARRIER_TOP_RST);
            carrier_compare = CAR_W'(IRPDT_CARRIER_COMPARE_RST);
            header_mark     = DUR_W'(IRPDT_HEADER_MARK_RST);
            header_space    = DUR_W'(IRPDT_HEADER_SPACE_RST);
            bit_mark        = DUR_W'(IRPDT_BIT_MARK_RST);
            one_space       = DUR_W'(IRPDT_ONE_SPACE_RST);
            zero_space      = DUR_W'(IRPDT_ZERO_SPACE_RST);
            phase           = TX_IDLE;
            seg_cnt         = '0;
            shift_word      = '0;
            bits_left       = '0;
            carrier_cnt     = '0;
            expected_q.delete();
            mismatches      = 0;
            beats_checked   = 0;
            frames_done     = 0;
            starts_refused  = 0;
            pending    <= 0;
            frame_busy <= 1'b0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                got.ir_drive       = result.ir_drive;
                got.envelope       = result.envelope;
                got.busy_res       = result.busy_res;
                got.start_rejected = result.start_rejected;
                if (expected_q.size() == 0)
                begin
                    if (mismatches < MAX_REPORTS)
                        $display("%0t: result beat %b with nothing outstanding", $time, got);
                    mismatches++;
                end
                else
                begin
                    exp = expected_q.pop_front();
                    beats_checked++;
                    if (got.ir_drive !== exp.ir_drive || got.envelope !== exp.envelope ||
                        got.busy_res !== exp.busy_res ||
                        got.start_rejected !== exp.start_rejected)
                    begin
                        if (mismatches < MAX_REPORTS)
                            $display("%0t: beat %0d drive/env/busy/rej exp %b%b%b%b got %b%b%b%b",
                                     $time, beats_checked, exp.ir_drive, exp.envelope,
                                     exp.busy_res, exp.start_rejected, got.ir_drive,
                                     got.envelope, got.busy_res, got.start_rejected);
                        mismatches++;
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    IRPDT_REG_CARRIER_TOP:     carrier_top     = cfg_data[CAR_W-1:0];
                    IRPDT_REG_CARRIER_COMPARE: carrier_compare = cfg_data[CAR_W-1:0];
                    IRPDT_REG_HEADER_MARK:     header_mark     = cfg_data[DUR_W-1:0];
                    IRPDT_REG_HEADER_SPACE:    header_space    = cfg_data[DUR_W-1:0];
                    IRPDT_REG_BIT_MARK:        bit_mark        = cfg_data[DUR_W-1:0];
                    IRPDT_REG_ONE_SPACE:       one_space       = cfg_data[DUR_W-1:0];
                    IRPDT_REG_ZERO_SPACE:      zero_space      = cfg_data[DUR_W-1:0];
                    default: ;
                endcase
            end
            if (item.valid && item.ready)
                expected_q.push_back(transmit_step(item.cmd, item.frame_word));
            pending    <= expected_q.size();
            frame_busy <= (phase != TX_IDLE);
        end
    end
endmodule

/* verif/tb.sv */
// Testbench top for the infrared transmitter: reset, register setup, stimulus and verdict.
`timescale 1ns / 100ps
module tb;
    import irpdt_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 5;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 5;
    localparam int DUR_W        = IRPDT_DURATION_WIDTH_DEF;
    localparam int CAR_W        = IRPDT_CARRIER_WIDTH_DEF;
    localparam int CFG_W        = (DUR_W > CAR_W) ? DUR_W : CAR_W;
    localparam int DUR_MAX      = (1 << DUR_W) - 1;
    localparam int CAR_MAX      = (1 << CAR_W) - 1;
    localparam int HEAVY_PCT    = 69;
    localparam int LIGHT_PCT    = 19;
    localparam logic [IRPDT_CFG_INDEX_WIDTH-1:0] REG_SPARE = 3'd7;
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_START = 1'b1;

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_we;
    logic [IRPDT_CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [CFG_W-1:0]                 cfg_data;

    int   mismatches;
    int   pending;
    int   beats_checked;
    int   frames_done;
    int   starts_refused;
    logic frame_busy;

    int gap_pct;
    int stall_pct;
    int hold_requests;
    int items_sent;
    int cfg_writes;
    int cycle_count;

    irpdt_in_if  item_ch();
    irpdt_out_if result_ch();

    ir_pulse_distance_transmitter uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_ch),
        .result    (result_ch)
    );

    irpdt_checker #(.CFG_W(CFG_W)) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .item           (item_ch),
        .result         (result_ch),
        .mismatches     (mismatches),
        .pending        (pending),
        .beats_checked  (beats_checked),
        .frames_done    (frames_done),
        .starts_refused (starts_refused),
        .frame_busy     (frame_busy)
    );

    initial clk = 1'b0;
    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // result side: random stalls plus the long hold-off on request
    initial
    begin
        int hold_left;
        int holds_served;
        hold_left    = 0;
        holds_served = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (holds_served != hold_requests)
            begin
                holds_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic offer_beat(input logic c, input logic [IRPDT_WORD_WIDTH-1:0] w);
        while ($urandom_range(99) < gap_pct)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid      <= 1'b1;
        item_ch.cmd        <= c;
        item_ch.frame_word <= w;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic settle();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // leaves cfg_we high; caller lowers it after the last write
    task automatic put_reg(input logic [IRPDT_CFG_INDEX_WIDTH-1:0] idx,
                           input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_writes++;
    endtask

    task automatic program_all(input int top, input int cmp, input int hm, input int hs,
                               input int bm, input int os, input int zs);
        logic [CFG_W-1:0] junk;
        junk = CFG_W'($urandom);
        // carrier registers get random upper bits, which must be dropped
        put_reg(IRPDT_REG_CARRIER_TOP, {junk[CFG_W-1:CAR_W], CAR_W'(top)});
        put_reg(IRPDT_REG_CARRIER_COMPARE, {~junk[CFG_W-1:CAR_W], CAR_W'(cmp)});
        put_reg(IRPDT_REG_HEADER_MARK, CFG_W'(hm));
        put_reg(IRPDT_REG_HEADER_SPACE, CFG_W'(hs));
        put_reg(IRPDT_REG_BIT_MARK, CFG_W'(bm));
        put_reg(IRPDT_REG_ONE_SPACE, CFG_W'(os));
        put_reg(IRPDT_REG_ZERO_SPACE, CFG_W'(zs));
        put_reg(REG_SPARE, junk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input int n_items, input int send_gap, input int sink_stall);
        int                          k;
        logic [IRPDT_WORD_WIDTH-1:0] w;
        logic                        go;
        gap_pct = send_gap;
        stall_pct <= sink_stall;
        for (k = 0; k < n_items; k++)
        begin
            case ($urandom_range(7))
                0:       w = '0;
                1:       w = '1;
                default: w = $urandom;
            endcase
            go = frame_busy ? ($urandom_range(99) < 3) : ($urandom_range(99) < 60);
            offer_beat(go ? CMD_START : CMD_TICK, w);
        end
        settle();
    endtask

    initial
    begin
        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= '0;
        cfg_data           <= '0;
        item_ch.valid      <= 1'b0;
        item_ch.cmd        <= CMD_TICK;
        item_ch.frame_word <= '0;
        gap_pct       = 0;
        stall_pct     <= 0;
        hold_requests <= 0;
        items_sent    = 0;
        cfg_writes    = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset timings, refused start, header length at maximum then at one
        offer_beat(CMD_TICK, 32'h0000_0000);
        offer_beat(CMD_START, 32'hC000_0001);
        offer_beat(CMD_START, 32'h0000_0000);
        offer_beat(CMD_TICK, 32'hFFFF_FFFF);
        offer_beat(CMD_TICK, 32'h0000_0000);
        offer_beat(CMD_TICK, 32'h5A5A_A5A5);
        settle();
        put_reg(IRPDT_REG_HEADER_MARK, CFG_W'(DUR_MAX));
        cfg_we <= 1'b0;
        offer_beat(CMD_TICK, 32'h0);
        offer_beat(CMD_TICK, 32'h0);
        settle();
        put_reg(IRPDT_REG_HEADER_MARK, CFG_W'(1));
        cfg_we <= 1'b0;
        offer_beat(CMD_TICK, 32'h0);
        offer_beat(CMD_TICK, 32'h0);
        settle();
        // carrier top lowered below the running count
        program_all(1, 1, 1, 1, 1, 2, 1);
        offer_beat(CMD_TICK, 32'h0);
        offer_beat(CMD_START, 32'hFFFF_FFFF);
        offer_beat(CMD_TICK, 32'h0);
        offer_beat(CMD_TICK, 32'h0);
        settle();

        run_phase(90, 0, 0);
        program_all(CAR_MAX, CAR_MAX, 2, 1, 1, 3, 1);
        run_phase(100, HEAVY_PCT, 0);
        program_all($urandom_range(12, 1), $urandom_range(13, 0), $urandom_range(3, 1),
                    $urandom_range(3, 1), $urandom_range(3, 1), $urandom_range(3, 1),
                    $urandom_range(3, 1));
        run_phase(100, 0, HEAVY_PCT);
        program_all(7, 3, 1, 2, 2, 1, 2);
        run_phase(100, LIGHT_PCT, LIGHT_PCT);
        program_all(2, 0, 1, 1, 1, 1, 1);
        hold_requests <= hold_requests + 1;
        run_phase(100, 0, 0);
        program_all($urandom_range(CAR_MAX, 1), $urandom_range(CAR_MAX, 0),
                    $urandom_range(4, 1), $urandom_range(4, 1), $urandom_range(2, 1),
                    $urandom_range(4, 1), $urandom_range(2, 1));
        run_phase(110, 0, 0);

        $display("Sent %0d item beats, checked %0d result beats, %0d frames sent in full.",
                 items_sent, beats_checked, frames_done);
        $display("%0d busy starts refused; %0d register writes over seven settings.",
                 starts_refused, cfg_writes);
        if (mismatches == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

/* ir_pulse_distance_transmitter.f */
+incdir+hdl
hdl/irpdt_pkg.sv
hdl/irpdt_if.sv
hdl/irpdt_core.sv
hdl/irpdt_outbuf.sv
hdl/ir_pulse_distance_transmitter.sv
verif/irpdt_checker.sv
verif/tb.sv
